### hdl/utf16_to_utf8_transcoder_macros.svh
// Assertion helpers for the transcoder. Both expect clk and rst in scope.
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define U16U8_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define U16U8_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### hdl/u16u8_pkg.sv
`timescale 1ns / 1ps
package u16u8_pkg;

  // Surrogate ranges and encoding limits.
  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] MAX_ONE    = 21'h7F;
  localparam logic [20:0] MAX_TWO    = 21'h7FF;
  localparam logic [20:0] MAX_THREE  = 21'hFFFF;
  localparam logic [7:0]  LEAD_TWO   = 8'hC0;
  localparam logic [7:0]  LEAD_THREE = 8'hE0;
  localparam logic [7:0]  LEAD_FOUR  = 8'hF0;
  localparam logic [7:0]  CONT_MARK  = 8'h80;
  localparam logic [5:0]  CONT_MASK  = 6'h3F;

  // Input transaction.
  typedef struct packed {
    logic [20:0] code_unit;
    logic        text_end;
  } unit_item_t;

  // Output transaction.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_last;
  } byte_item_t;

  // One queued job: one or two code points to encode, in order.
  typedef struct packed {
    logic [20:0] first;
    logic [20:0] second;
    logic        two;
    logic        text_end;
  } job_t;

  // Number of UTF-8 bytes minus one for a code point.
  function automatic logic [1:0] last_index(input logic [20:0] cp);
    logic [1:0] r;
    if (cp <= MAX_ONE) begin
      r = 2'd0;
    end else if (cp <= MAX_TWO) begin
      r = 2'd1;
    end else if (cp <= MAX_THREE) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  // Byte number idx of the encoding of cp, whose last byte index is li.
  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] li,
                                          input logic [1:0] idx);
    logic [7:0] r;
    logic [1:0] from_end;
    from_end = li - idx;
    if (idx == 2'd0) begin
      case (li)
        2'd0: r = {1'b0, cp[6:0]};
        2'd1: r = LEAD_TWO | {3'b000, cp[10:6]};
        2'd2: r = LEAD_THREE | {4'b0000, cp[15:12]};
        default: r = LEAD_FOUR | {5'b00000, cp[20:18]};
      endcase
    end else begin
      case (from_end)
        2'd0: r = CONT_MARK | {2'b00, cp[5:0] & CONT_MASK};
        2'd1: r = CONT_MARK | {2'b00, cp[11:6] & CONT_MASK};
        default: r = CONT_MARK | {2'b00, cp[17:12] & CONT_MASK};
      endcase
    end
    return r;
  endfunction

endpackage

### hdl/u16u8_front.sv
`timescale 1ns / 1ps
module u16u8_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_data,
  input  logic                  accept,
  input  u16u8_pkg::unit_item_t item,
  output logic                  push,
  output u16u8_pkg::job_t       job
);

  logic       whole;
  logic [9:0] pending_high;
  logic       pending_valid;
  logic [9:0] pending_high_next;
  logic       pending_valid_next;

  logic [15:0] unit16;
  logic        is_low;
  logic        is_high;
  logic [20:0] merged;

  // Classify the unit.
  assign unit16  = item.code_unit[15:0];
  assign is_low  = (unit16 >= u16u8_pkg::LOW_FIRST) && (unit16 <= u16u8_pkg::LOW_LAST);
  assign is_high = (unit16 >= u16u8_pkg::HIGH_FIRST) && (unit16 <= u16u8_pkg::HIGH_LAST);
  assign merged  = u16u8_pkg::SUPP_BASE + {1'b0, pending_high, unit16[9:0]};

  // Build the job and the next surrogate state.
  always_comb begin
    push               = 1'b0;
    job.first          = item.code_unit;
    job.second         = {5'b00000, unit16};
    job.two            = 1'b0;
    job.text_end       = item.text_end;
    pending_high_next  = pending_high;
    pending_valid_next = pending_valid;
    if (accept) begin
      if (whole) begin
        push = 1'b1;
      end else if (pending_valid && is_low) begin
        push               = 1'b1;
        job.first          = merged;
        pending_valid_next = 1'b0;
        pending_high_next  = '0;
      end else begin
        pending_valid_next = 1'b0;
        pending_high_next  = '0;
        if (pending_valid) begin
          // Lone held surrogate goes out first.
          push      = 1'b1;
          job.first = {5'b00000, u16u8_pkg::HIGH_FIRST | {6'b000000, pending_high}};
        end else begin
          job.first = {5'b00000, unit16};
        end
        if (is_high && !item.text_end) begin
          pending_valid_next = 1'b1;
          pending_high_next  = unit16[9:0];
        end else begin
          push    = 1'b1;
          job.two = pending_valid;
        end
      end
    end
  end

  // Mode register and held surrogate; a register write drops anything held.
  always_ff @(posedge clk) begin
    if (rst) begin
      whole         <= 1'b0;
      pending_valid <= 1'b0;
      pending_high  <= '0;
    end else if (cfg_valid) begin
      whole         <= cfg_data;
      pending_valid <= 1'b0;
      pending_high  <= '0;
    end else begin
      pending_valid <= pending_valid_next;
      pending_high  <= pending_high_next;
    end
  end

endmodule

### hdl/u16u8_queue.sv
`timescale 1ns / 1ps
module u16u8_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  input  logic            pop,
  output u16u8_pkg::job_t head,
  output logic            empty,
  output logic            full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u16u8_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = slots[rd_ptr];

  // Storage, written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/u16u8_back.sv
`timescale 1ns / 1ps
module u16u8_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  input  u16u8_pkg::job_t       head,
  output logic                  pop,
  output logic                  byte_valid,
  input  logic                  byte_stall,
  output u16u8_pkg::byte_item_t byte_data
);

  logic [1:0]  idx;
  logic        on_second;
  logic [1:0]  idx_next;
  logic        on_second_next;
  logic [20:0] cp;
  logic [1:0]  li;
  logic        cp_done;
  logic        job_done;
  logic        advance;

  // Pick the code point and byte under work.
  assign cp       = on_second ? head.second : head.first;
  assign li       = u16u8_pkg::last_index(cp);
  assign cp_done  = (idx == li);
  assign job_done = cp_done && (on_second || !head.two);
  assign advance  = !empty && (!byte_valid || !byte_stall);
  assign pop      = advance && job_done;

  // Step through the bytes of the job.
  always_comb begin
    idx_next       = idx;
    on_second_next = on_second;
    if (advance) begin
      if (job_done) begin
        idx_next       = '0;
        on_second_next = 1'b0;
      end else if (cp_done) begin
        idx_next       = '0;
        on_second_next = 1'b1;
      end else begin
        idx_next = idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      on_second <= 1'b0;
    end else begin
      idx       <= idx_next;
      on_second <= on_second_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (advance) begin
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_data.out_byte  <= u16u8_pkg::enc_byte(cp, li, idx);
      byte_data.run_last  <= job_done;
      byte_data.text_last <= job_done && head.text_end;
    end
  end

endmodule

### hdl/utf16_to_utf8_transcoder.sv
// UTF-16 (or whole code point) to UTF-8 transcoder.
// Input channel unit_valid/unit_stall/unit_data carries one code unit and a
// text-end flag per transaction. Output channel byte_valid/byte_stall/byte_data
// carries one UTF-8 byte per transaction, marked on the last byte of each unit
// and on the last byte of a text. cfg_valid/cfg_ready/cfg_data sets the mode
// (0: UTF-16 with surrogate pairing, 1: 21-bit code points); cfg_ready is
// always high and a write drops a held high surrogate.
// A taken unit's job passes the job queue, then the output register, before
// its first byte is shown. Throughput: one byte per cycle out of the byte
// serializer while byte_stall is low; a unit yields 1 to 4 bytes, up to 6
// when a held surrogate is flushed. A high surrogate that is held
// yields no byte until the next unit. A job queue of QUEUE_DEPTH entries sits
// between the classifier and the serializer; unit_stall rises when it fills.
// Reset clears the mode to UTF-16, the held surrogate, the queue and the
// output register. When the receiver stalls, the output byte holds and the
// input keeps being taken until the queue fills.
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_macros.svh"
module utf16_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,
  input  logic                  unit_valid,
  output logic                  unit_stall,
  input  u16u8_pkg::unit_item_t unit_data,
  output logic                  byte_valid,
  input  logic                  byte_stall,
  output u16u8_pkg::byte_item_t byte_data
);

  logic            accept;
  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  logic            q_full;
  u16u8_pkg::job_t push_job;
  u16u8_pkg::job_t head_job;

  assign cfg_ready  = 1'b1;
  assign unit_stall = q_full;
  assign accept     = unit_valid && !q_full;

  // Classifier and surrogate holder.
  u16u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (unit_data),
    .push     (q_push),
    .job      (push_job)
  );

  // Job queue.
  u16u8_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .head    (head_job),
    .empty   (q_empty),
    .full    (q_full)
  );

  // Byte serializer.
  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (head_job),
    .pop       (q_pop),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data (byte_data)
  );

  // Checks on the queue and the output framing.
  `U16U8_ASSERT_NOW(a_no_overflow, q_push, !q_full, "job queue overflow")
  `U16U8_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "job queue underflow")
  `U16U8_ASSERT_NEXT(a_push_lands, q_push, !q_empty, "pushed job missing from queue")
  `U16U8_ASSERT_NOW(a_text_last_ends_run, byte_valid && byte_data.text_last,
                    byte_data.run_last, "text end byte not marked as run end")

endmodule

### dv/utf16_to_utf8_transcoder_tb.sv
`timescale 1ns / 1ps
module utf16_to_utf8_transcoder_tb;

  // Mode register values.
  localparam logic MODE_UTF16 = 1'b0;
  localparam logic MODE_WHOLE = 1'b1;

  // Quiet cycles after the last byte, and the stall watchdog limit.
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_data;
  logic                  unit_valid;
  logic                  unit_stall;
  u16u8_pkg::unit_item_t unit_data;
  logic                  byte_valid;
  logic                  byte_stall = 1'b0;
  u16u8_pkg::byte_item_t byte_data;

  // Predicted UTF-8 bytes still to come out of the block.
  u16u8_pkg::byte_item_t expected_bytes[$];

  // Shadow copy of the mode and of the held high surrogate.
  logic       whole_mode = MODE_UTF16;
  logic       held_valid = 1'b0;
  logic [9:0] held_high  = '0;

  // Run statistics and failure count.
  int mismatches    = 0;
  int units_sent    = 0;
  int bytes_checked = 0;
  int mode_writes   = 0;
  int idle_cycles   = 0;
  int stall_left    = 0;
  bit calm          = 1'b0;
  u16u8_pkg::byte_item_t want_byte;

  utf16_to_utf8_transcoder uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_data  (unit_data),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data)
  );

  // Free-running 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    u16u8_pkg::byte_item_t item;
    item.out_byte  = b;
    item.run_last  = 1'b0;
    item.text_last = 1'b0;
    expected_bytes.insert(expected_bytes.size(), item);
  endfunction

  // UTF-8 encoding of one 21-bit code point.
  function automatic void push_code_point(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      push_byte({1'b0, cp[6:0]});
    end else if (cp <= 21'h7FF) begin
      push_byte({3'b110, cp[10:6]});
      push_byte({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      push_byte({4'b1110, cp[15:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end else begin
      push_byte({5'b11110, cp[20:18]});
      push_byte({2'b10, cp[17:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end
  endfunction

  // Predicts the bytes caused by one accepted code unit and updates the shadow state.
  function automatic void predict_unit(u16u8_pkg::unit_item_t it);
    int first;
    logic [15:0] u;
    logic is_low;
    logic is_high;
    u16u8_pkg::byte_item_t tail;
    first   = expected_bytes.size();
    u       = it.code_unit[15:0];
    is_low  = (u >= u16u8_pkg::LOW_FIRST) && (u <= u16u8_pkg::LOW_LAST);
    is_high = (u >= u16u8_pkg::HIGH_FIRST) && (u <= u16u8_pkg::HIGH_LAST);
    if (whole_mode == MODE_WHOLE) begin
      push_code_point(it.code_unit);
    end else if (held_valid && is_low) begin
      push_code_point(21'h10000 + {1'b0, held_high, u[9:0]});
      held_valid = 1'b0;
      held_high  = '0;
    end else begin
      // A held surrogate that is not followed by a low one goes out alone.
      if (held_valid) begin
        push_code_point({5'b0, 6'b110110, held_high});
        held_valid = 1'b0;
        held_high  = '0;
      end
      if (is_high && !it.text_end) begin
        held_high  = u[9:0];
        held_valid = 1'b1;
      end else begin
        push_code_point({5'b0, u});
      end
    end
    // Mark the last byte of this unit, and of the text when it ends here.
    if (expected_bytes.size() > first) begin
      tail = expected_bytes[expected_bytes.size() - 1];
      tail.run_last  = 1'b1;
      tail.text_last = it.text_end;
      expected_bytes[expected_bytes.size() - 1] = tail;
    end
  endfunction

  // Sends one code unit transaction after a random gap.
  task automatic send_unit(input logic [20:0] cu, input logic te);
    int gap;
    u16u8_pkg::unit_item_t it;
    gap = pick_gap();
    it.code_unit = cu;
    it.text_end  = te;
    if (gap > 0) begin
      unit_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    unit_valid <= 1'b1;
    unit_data  <= it;
    do @(posedge clk); while (unit_stall);
    predict_unit(it);
    units_sent++;
  endtask

  // Stops sending and waits until every predicted byte has arrived.
  task automatic drain();
    unit_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the mode register while the block is idle.
  task automatic write_mode(input logic mode);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    whole_mode = mode;
    held_valid = 1'b0;
    held_high  = '0;
    mode_writes++;
  endtask

  // One random UTF-16 character, sometimes a surrogate pair, with some noise.
  task automatic send_random_utf16();
    int r;
    logic [4:0] junk;
    logic [15:0] v16;
    logic te;
    r    = $urandom_range(0, 99);
    junk = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(1, 31)) : 5'd0;
    te   = ($urandom_range(0, 7) == 0);
    if (r < 30) begin
      send_unit({junk, 16'($urandom_range(0, 16'h7F))}, te);
    end else if (r < 45) begin
      send_unit({junk, 16'($urandom_range(16'h80, 16'h7FF))}, te);
    end else if (r < 60) begin
      v16 = 16'($urandom_range(16'h800, 16'hFFFF));
      if (v16 >= u16u8_pkg::HIGH_FIRST && v16 <= u16u8_pkg::LOW_LAST) begin
        v16 = v16 ^ 16'h2000;
      end
      send_unit({junk, v16}, te);
    end else if (r < 82) begin
      send_unit({junk, 6'b110110, 10'($urandom)}, 1'b0);
      send_unit({5'($urandom), 6'b110111, 10'($urandom)}, te);
    end else if (r < 88) begin
      send_unit({junk, 6'b110110, 10'($urandom)}, te);
    end else if (r < 93) begin
      send_unit({junk, 6'b110111, 10'($urandom)}, te);
    end else begin
      send_unit(21'($urandom), te);
    end
  endtask

  // Range edges, surrogate pairing, flushes and ignored upper bits in UTF-16 mode.
  task automatic test_utf16_directed();
    send_unit(21'h000000, 1'b0);
    send_unit(21'h00007F, 1'b0);
    send_unit(21'h000080, 1'b0);
    send_unit(21'h0007FF, 1'b0);
    send_unit(21'h000800, 1'b0);
    send_unit(21'h00FFFF, 1'b1);
    send_unit(21'h1F0041, 1'b0);
    send_unit(21'h00D800, 1'b0);
    send_unit(21'h00DC00, 1'b0);
    send_unit(21'h00DBFF, 1'b0);
    send_unit(21'h00DFFF, 1'b1);
    // A high surrogate at the end of a text is emitted on its own.
    send_unit(21'h00DABC, 1'b1);
    send_unit(21'h00D9AA, 1'b0);
    send_unit(21'h000041, 1'b0);
    // Two high surrogates in a row, then a BMP character: six bytes at once.
    send_unit(21'h00D801, 1'b0);
    send_unit(21'h00DB00, 1'b0);
    send_unit(21'h00E000, 1'b0);
    send_unit(21'h00DC00, 1'b0);
    send_unit(21'h00DFFF, 1'b1);
    send_unit(21'h00D800, 1'b0);
    send_unit(21'h1FDC05, 1'b1);
  endtask

  // A mode write drops a held high surrogate, so the next low one stands alone.
  task automatic test_write_drops_held();
    write_mode(MODE_UTF16);
    send_unit(21'h00DB40, 1'b0);
    write_mode(MODE_UTF16);
    send_unit(21'h00DC01, 1'b1);
  endtask

  // Range edges in whole code point mode, including values past 0x10FFFF.
  task automatic test_whole_directed();
    write_mode(MODE_WHOLE);
    send_unit(21'h000000, 1'b0);
    send_unit(21'h00007F, 1'b0);
    send_unit(21'h000080, 1'b0);
    send_unit(21'h0007FF, 1'b0);
    send_unit(21'h000800, 1'b0);
    send_unit(21'h00D800, 1'b0);
    send_unit(21'h00DC00, 1'b1);
    send_unit(21'h00FFFF, 1'b0);
    send_unit(21'h010000, 1'b0);
    send_unit(21'h10FFFF, 1'b0);
    send_unit(21'h110000, 1'b0);
    send_unit(21'h1FFFFF, 1'b1);
  endtask

  // Random UTF-16 text with random idling on both sides.
  task automatic test_utf16_random();
    int start;
    write_mode(MODE_UTF16);
    start = units_sent;
    while (units_sent - start < 140) send_random_utf16();
  endtask

  // Bursts separated by full drains of the output.
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (10) send_random_utf16();
      drain();
    end
  endtask

  // Random code points of every length in whole mode.
  task automatic test_whole_random();
    int r;
    logic [20:0] cp;
    write_mode(MODE_WHOLE);
    repeat (90) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        cp = 21'($urandom_range(0, 21'h7F));
      end else if (r < 35) begin
        cp = 21'($urandom_range(21'h80, 21'h7FF));
      end else if (r < 55) begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
      end else if (r < 80) begin
        cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      end else if (r < 90) begin
        cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
      end else begin
        cp = 21'($urandom);
      end
      send_unit(cp, ($urandom_range(0, 7) == 0));
    end
  endtask

  // Back-to-back transactions with no idling, in both modes.
  task automatic test_back_to_back();
    calm = 1'b1;
    write_mode(MODE_WHOLE);
    repeat (20) send_unit(21'($urandom_range(0, 21'h1FFFFF)), ($urandom_range(0, 3) == 0));
    write_mode(MODE_UTF16);
    repeat (20) send_random_utf16();
    drain();
    calm = 1'b0;
  endtask

  // Random stall on the byte channel.
  always @(posedge clk) begin
    if (rst) begin
      byte_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      byte_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      byte_stall <= (stall_left > 0);
      if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  // Compares every accepted byte with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $write("%0t: unexpected byte, expected none, ", $time);
        $display("actual byte=%02h run_last=%0b text_last=%0b",
                 byte_data.out_byte, byte_data.run_last, byte_data.text_last);
      end else begin
        want_byte = expected_bytes.pop_front();
        bytes_checked++;
        if (byte_data.out_byte !== want_byte.out_byte ||
            byte_data.run_last !== want_byte.run_last ||
            byte_data.text_last !== want_byte.text_last) begin
          mismatches++;
          $write("%0t: byte mismatch, expected byte=%02h run_last=%0b text_last=%0b, ",
                 $time, want_byte.out_byte, want_byte.run_last, want_byte.text_last);
          $display("actual byte=%02h run_last=%0b text_last=%0b",
                   byte_data.out_byte, byte_data.run_last, byte_data.text_last);
        end
      end
    end
  end

  // Ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (unit_valid && !unit_stall) || (byte_valid && !byte_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d bytes still expected",
                 $time, IDLE_LIMIT, expected_bytes.size());
        $display("FAIL utf16_to_utf8_transcoder");
        $finish;
      end
    end
  end

  // Reset, then each test in turn.
  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    unit_valid = 1'b0;
    unit_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_utf16_directed();
    test_write_drops_held();
    test_whole_directed();
    test_utf16_random();
    test_drain_pause();
    test_whole_random();
    test_back_to_back();
    drain();

    $display("Sent %0d code units and checked %0d UTF-8 bytes over %0d mode writes,",
             units_sent, bytes_checked, mode_writes);
    $display("covering surrogate pairs, lone and flushed surrogates, and 21-bit code points.");
    if (mismatches == 0) begin
      $display("PASS utf16_to_utf8_transcoder");
    end else begin
      $display("FAIL utf16_to_utf8_transcoder");
    end
    $finish;
  end

endmodule
